[sv/lsgs_pkg.sv]
// Shared constants, types and helper functions of the layer score gated summer.
// Used by the controller, the datapath, the top level and the testbench; it depends on nothing else.

package lsgs_pkg;

   // Sizing of the score store.
   localparam int NUM_LAYERS     = 18;
   localparam int NUM_REF_LAYERS = 8;
   localparam int SCORE_BITS     = 12;

   localparam int LAYER_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
   localparam int REF_W   = (NUM_REF_LAYERS > 1) ? $clog2(NUM_REF_LAYERS) : 1;
   localparam int DEPTH   = NUM_LAYERS * NUM_REF_LAYERS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Fixed field widths of the ports.
   localparam int REF_IN_W   = 3;
   localparam int LAYER_IN_W = 5;
   localparam int SCORE_IN_W = 12;
   localparam int PHI_W      = 12;
   localparam int SUM_W      = 17;
   localparam int HIT_W      = 5;

   // Register file layout.
   localparam int MASK_W        = 18;
   localparam int MAP_LOW_W     = 60;
   localparam int MAP_HIGH_W    = 30;
   localparam int MAP_FIELD_W   = 5;
   localparam int LOW_LAYERS    = 12;
   localparam int MAPPED_LAYERS = 18;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 60;

   localparam logic [CSR_IDX_W-1:0] CSR_BENDING_MASK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_LOW      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HIGH     = 2'd2;

   localparam logic [MASK_W-1:0]     BENDING_RESET  = '0;
   localparam logic [MAP_LOW_W-1:0]  MAP_LOW_RESET  = 60'd407901468851537952;
   localparam logic [MAP_HIGH_W-1:0] MAP_HIGH_RESET = 30'd587708844;

   localparam logic [PHI_W-1:0] PHI_RESET = 12'd1024;
   localparam logic [SUM_W-1:0] SUM_MAX   = '1;
   localparam logic [HIT_W-1:0] HIT_MAX   = '1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               accept;       // an input item is taken this cycle
      logic               issue;        // read one layer and its partner
      logic [LAYER_W-1:0] layer;
      logic [REF_W-1:0]   ref_idx;
      logic               first_layer;  // first layer of a reference layer
      logic               last_layer;   // last layer of a reference layer
      logic               last_ref;     // final reference layer of the walk
      logic               clear;        // empty the store at the end of the walk
   } lsgs_cmd_type;

   // Partner layer of a layer; layers without a map entry pair with themselves.
   function automatic logic [MAP_FIELD_W-1:0] partner_of(
      input logic [MAP_FIELD_W-1:0] l,
      input logic [MAP_LOW_W-1:0]   map_low,
      input logic [MAP_HIGH_W-1:0]  map_high
   );
      logic [MAP_FIELD_W-1:0] p;
      p = l;
      if (int'(l) < LOW_LAYERS) begin
         p = map_low[MAP_FIELD_W*int'(l) +: MAP_FIELD_W];
      end else if (int'(l) < MAPPED_LAYERS) begin
         p = map_high[MAP_FIELD_W*(int'(l) - LOW_LAYERS) +: MAP_FIELD_W];
      end
      return p;
   endfunction

   // Bending flag of a layer; layers without a mask bit never bend.
   function automatic logic is_bending(
      input logic [MAP_FIELD_W-1:0] l,
      input logic [MASK_W-1:0]      mask
   );
      logic b;
      b = 1'b0;
      if (int'(l) < MAPPED_LAYERS) begin
         b = mask[l];
      end
      return b;
   endfunction

endpackage

[sv/lsgs_ram.sv]
// Generic RAM with one write port and two registered read ports.
// Stand-alone; it uses no package.

module lsgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Two read ports with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

[sv/lsgs_ctrl.sv]
// Controller of the layer score gated summer: idle, walk and drain sequencing.
// Depends on lsgs_pkg for sizes and the command struct.

module lsgs_ctrl import lsgs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         req_last,
   output logic         busy,
   output lsgs_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_WALK  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [LAYER_W-1:0] layer_ff, layer_in;
   logic [REF_W-1:0]   ref_ff, ref_in;
   logic               accept;
   logic               layer_end, ref_end;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign layer_end = (int'(layer_ff) == NUM_LAYERS - 1);
   assign ref_end   = (int'(ref_ff) == NUM_REF_LAYERS - 1);

   // Next state and walk counters.
   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      ref_in   = ref_ff;
      unique case (state_ff)
         ST_IDLE: begin
            layer_in = '0;
            ref_in   = '0;
            if (accept && req_last) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (layer_end) begin
               layer_in = '0;
               if (ref_end) begin
                  state_in = ST_DRAIN;
               end else begin
                  ref_in = ref_ff + 1'b1;
               end
            end else begin
               layer_in = layer_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         layer_ff <= '0;
         ref_ff   <= '0;
      end else begin
         state_ff <= state_in;
         layer_ff <= layer_in;
         ref_ff   <= ref_in;
      end
   end

   // Commands to the datapath.
   always_comb begin
      cmd.accept      = accept;
      cmd.issue       = (state_ff == ST_WALK);
      cmd.layer       = layer_ff;
      cmd.ref_idx     = ref_ff;
      cmd.first_layer = (layer_ff == '0);
      cmd.last_layer  = layer_end;
      cmd.last_ref    = ref_end;
      cmd.clear       = (state_ff == ST_DRAIN);
   end

endmodule

[sv/lsgs_dp.sv]
// Datapath of the layer score gated summer: registers, score memory, phi store,
// gated accumulation and result registers. Depends on lsgs_pkg and lsgs_ram.

module lsgs_dp import lsgs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  lsgs_cmd_type             cmd,
   input  logic [REF_IN_W-1:0]      req_ref_layer,
   input  logic [LAYER_IN_W-1:0]    req_layer,
   input  logic [SCORE_IN_W-1:0]    req_score,
   input  logic signed [PHI_W-1:0]  req_ref_phi,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata,
   output logic                     rsp_valid,
   output logic [REF_IN_W-1:0]      rsp_out_ref_layer,
   output logic [SUM_W-1:0]         rsp_score_sum,
   output logic [HIT_W-1:0]         rsp_hit_count,
   output logic signed [PHI_W-1:0]  rsp_out_ref_phi,
   output logic                     rsp_last_of_run
);

   // Configuration registers.
   logic [MASK_W-1:0]     bending_ff;
   logic [MAP_LOW_W-1:0]  map_low_ff;
   logic [MAP_HIGH_W-1:0] map_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bending_ff  <= BENDING_RESET;
         map_low_ff  <= MAP_LOW_RESET;
         map_high_ff <= MAP_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BENDING_MASK: bending_ff  <= csr_wdata[MASK_W-1:0];
            CSR_MAP_LOW:      map_low_ff  <= csr_wdata[MAP_LOW_W-1:0];
            CSR_MAP_HIGH:     map_high_ff <= csr_wdata[MAP_HIGH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Store write from an accepted item whose indexes are in range.
   logic              in_range, wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [REF_W-1:0]  wr_ref;

   assign in_range = (int'(req_layer) < NUM_LAYERS) && (int'(req_ref_layer) < NUM_REF_LAYERS);
   assign wr_en    = cmd.accept && in_range;
   assign wr_addr  = ADDR_W'(int'(req_ref_layer) * NUM_LAYERS + int'(req_layer));
   assign wr_ref   = REF_W'(req_ref_layer);

   // One valid bit per score entry; an entry not written since the last clear reads as zero.
   logic [DEPTH-1:0] vld_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Reference phi per reference layer.
   logic [PHI_W-1:0] phi_ff [NUM_REF_LAYERS];

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < NUM_REF_LAYERS; i++) begin
            phi_ff[i] <= PHI_RESET;
         end
      end else if (wr_en) begin
         phi_ff[wr_ref] <= req_ref_phi;
      end
   end

   // Read addresses for one layer and its partner.
   logic [MAP_FIELD_W-1:0] partner;
   logic                   partner_ok;
   logic [ADDR_W-1:0]      rd_addr_a, rd_addr_b;
   logic [SCORE_BITS-1:0]  score_l, score_p;

   assign partner    = partner_of(MAP_FIELD_W'(cmd.layer), map_low_ff, map_high_ff);
   assign partner_ok = (int'(partner) < NUM_LAYERS);
   assign rd_addr_a  = ADDR_W'(int'(cmd.ref_idx) * NUM_LAYERS + int'(cmd.layer));
   assign rd_addr_b  = ADDR_W'(int'(cmd.ref_idx) * NUM_LAYERS +
                               (partner_ok ? int'(partner) : 0));

   lsgs_ram #(
      .WIDTH (SCORE_BITS),
      .DEPTH (DEPTH)
   ) u_score_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (SCORE_BITS'(req_score)),
      .rd_en     (cmd.issue),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (score_l),
      .rd_data_b (score_p)
   );

   // Stage that lines up with the registered memory read.
   logic                   s1_vld_ff;
   logic                   s1_first_ff, s1_last_ff, s1_last_ref_ff;
   logic                   s1_pok_ff, s1_lv_ff, s1_pv_ff, s1_bend_ff;
   logic [REF_W-1:0]       s1_ref_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         s1_first_ff    <= cmd.first_layer;
         s1_last_ff     <= cmd.last_layer;
         s1_last_ref_ff <= cmd.last_ref;
         s1_ref_ff      <= cmd.ref_idx;
         s1_pok_ff      <= partner_ok;
         s1_lv_ff       <= vld_ff[rd_addr_a];
         s1_pv_ff       <= vld_ff[rd_addr_b];
         s1_bend_ff     <= is_bending(MAP_FIELD_W'(cmd.layer), bending_ff);
      end
   end

   // Gated score of the layer and the running sums.
   logic [SCORE_BITS-1:0] gated;
   logic [SUM_W-1:0]      sum_ff, sum_base, sum_in;
   logic [SUM_W:0]        sum_wide;
   logic [HIT_W-1:0]      hit_ff, hit_base, hit_in;

   always_comb begin
      gated = '0;
      if (s1_pok_ff && s1_pv_ff && (score_p != '0) && s1_lv_ff) begin
         gated = score_l;
      end
      sum_base = s1_first_ff ? '0 : sum_ff;
      hit_base = s1_first_ff ? '0 : hit_ff;
      sum_wide = {1'b0, sum_base} + (SUM_W+1)'(gated);
      sum_in   = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];
      hit_in   = hit_base;
      if ((gated != '0) && !s1_bend_ff && (hit_base < HIT_MAX)) begin
         hit_in = hit_base + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         sum_ff <= sum_in;
         hit_ff <= hit_in;
      end
   end

   // Result registers, loaded on the last layer of each reference layer.
   logic                 rsp_valid_ff;
   logic [REF_IN_W-1:0]  rsp_ref_ff;
   logic [SUM_W-1:0]     rsp_sum_ff;
   logic [HIT_W-1:0]     rsp_hit_ff;
   logic [PHI_W-1:0]     rsp_phi_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_vld_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff && s1_last_ff) begin
         rsp_ref_ff  <= REF_IN_W'(s1_ref_ff);
         rsp_sum_ff  <= sum_in;
         rsp_hit_ff  <= hit_in;
         rsp_phi_ff  <= phi_ff[s1_ref_ff];
         rsp_last_ff <= s1_last_ref_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_ref_layer = rsp_ref_ff;
   assign rsp_score_sum     = rsp_sum_ff;
   assign rsp_hit_count     = rsp_hit_ff;
   assign rsp_out_ref_phi   = $signed(rsp_phi_ff);
   assign rsp_last_of_run   = rsp_last_ff;

endmodule

[sv/layer_score_gated_summer.sv]
// Top level of the layer score gated summer: controller plus datapath.
// Depends on lsgs_pkg, lsgs_ctrl, lsgs_dp and, through the datapath, lsgs_ram.

// The block takes one score item per clock while busy is low. An item marked
// last starts the end-of-event walk: for each reference layer in ascending
// order the controller steps through all 18 layers, one layer per cycle, using
// the two read ports of the score memory (the layer and its partner layer).
// The walk keeps busy high through the 18 x 8 layer reads and one drain state
// and sends one result per reference layer, registered after the memory read
// and the summing stage. Results carry a one-cycle strobe on rsp_valid and
// cannot be stalled. The store empties in the final walk cycle, so the next
// event can start at once; no clearing pass is needed after reset either.
// Configuration registers are always ready and should be written while idle.

module layer_score_gated_summer import lsgs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [REF_IN_W-1:0]      req_ref_layer,
   input  logic [LAYER_IN_W-1:0]    req_layer,
   input  logic [SCORE_IN_W-1:0]    req_score,
   input  logic signed [PHI_W-1:0]  req_ref_phi,
   input  logic                     req_last,
   output logic                     rsp_valid,
   output logic [REF_IN_W-1:0]      rsp_out_ref_layer,
   output logic [SUM_W-1:0]         rsp_score_sum,
   output logic [HIT_W-1:0]         rsp_hit_count,
   output logic signed [PHI_W-1:0]  rsp_out_ref_phi,
   output logic                     rsp_last_of_run,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wdata
);

   lsgs_cmd_type cmd;

   // Configuration writes are taken in any cycle.
   assign csr_ready = 1'b1;

   lsgs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .busy     (busy),
      .cmd      (cmd)
   );

   lsgs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_ref_layer     (req_ref_layer),
      .req_layer         (req_layer),
      .req_score         (req_score),
      .req_ref_phi       (req_ref_phi),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_valid),
      .rsp_out_ref_layer (rsp_out_ref_layer),
      .rsp_score_sum     (rsp_score_sum),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_out_ref_phi   (rsp_out_ref_phi),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

[sv/lsgs_chk.sv]
// Port-level checker of the layer score gated summer, bound to the top level.
// Stand-alone; it uses no package.

module lsgs_chk (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_last_of_run
);

   // An item that does not end the event leaves the block free for the next one.
   a_plain_item_free: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_last |=> !busy)
      else $error("block went busy after an item without the last mark");

   // An item that ends the event starts the walk.
   a_last_item_walks: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last |=> busy)
      else $error("last item did not start the walk");

   // Results before the final one come only during the walk.
   a_mid_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> busy)
      else $error("intermediate result outside the walk");

   // The walk ends together with the final result of the event.
   a_walk_end_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid && rsp_last_of_run)
      else $error("walk ended without the final result");

endmodule

bind layer_score_gated_summer lsgs_chk u_chk (.*);

[verif/testbench.sv]
// Self-checking testbench for layer_score_gated_summer: events of score items,
// an end-of-event prediction of every reference layer result, and checks.
// Depends on lsgs_pkg and the layer_score_gated_summer RTL.
`timescale 1ns / 100ps

module testbench;
   import lsgs_pkg::*;

   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 14;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [REF_IN_W-1:0]     ref_layer;
      logic [LAYER_IN_W-1:0]   layer;
      logic [SCORE_IN_W-1:0]   score;
      logic signed [PHI_W-1:0] ref_phi;
      logic                    last;
   } score_item_type;

   typedef struct packed {
      logic [REF_IN_W-1:0]     ref_layer;
      logic [SUM_W-1:0]        score_sum;
      logic [HIT_W-1:0]        hit_count;
      logic signed [PHI_W-1:0] ref_phi;
      logic                    last_of_run;
   } ref_total_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [REF_IN_W-1:0]     req_ref_layer = '0;
   logic [LAYER_IN_W-1:0]   req_layer = '0;
   logic [SCORE_IN_W-1:0]   req_score = '0;
   logic signed [PHI_W-1:0] req_ref_phi = '0;
   logic                    req_last = 1'b0;
   logic                    rsp_valid;
   logic [REF_IN_W-1:0]     rsp_out_ref_layer;
   logic [SUM_W-1:0]        rsp_score_sum;
   logic [HIT_W-1:0]        rsp_hit_count;
   logic signed [PHI_W-1:0] rsp_out_ref_phi;
   logic                    rsp_last_of_run;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;

   // Stimulus bookkeeping shared by the sequence, the driver and the monitor.
   score_item_type pending_items[$];
   ref_total_type  expected_totals[$];
   int          items_queued = 0;
   int          items_taken = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;
   bit          calm = 1'b0;
   bit          item_accepted = 1'b0;
   bit          csr_taken = 1'b0;

   // Shadow copy of the block's registers and score store.
   logic [MASK_W-1:0]       cfg_bending;
   logic [MAP_LOW_W-1:0]    cfg_map_low;
   logic [MAP_HIGH_W-1:0]   cfg_map_high;
   logic [SCORE_BITS-1:0]   score_mem [NUM_LAYERS][NUM_REF_LAYERS];
   logic signed [PHI_W-1:0] phi_mem [NUM_REF_LAYERS];

   layer_score_gated_summer DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_ref_layer     (req_ref_layer),
      .req_layer         (req_layer),
      .req_score         (req_score),
      .req_ref_phi       (req_ref_phi),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_out_ref_layer (rsp_out_ref_layer),
      .rsp_score_sum     (rsp_score_sum),
      .rsp_hit_count     (rsp_hit_count),
      .rsp_out_ref_phi   (rsp_out_ref_phi),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** layer_score_gated_summer: FAILED **");
         $finish;
      end
   end

   // Empties the shadow store the way the block does after each event.
   function automatic void clear_event_store();
      foreach (score_mem[l, r]) begin
         score_mem[l][r] = '0;
      end
      foreach (phi_mem[r]) begin
         phi_mem[r] = PHI_RESET;
      end
   endfunction

   // Partner layer of a mapped layer, from the shadow map registers.
   function automatic int partner_layer(int l);
      if (l < LOW_LAYERS) begin
         return int'(cfg_map_low[MAP_FIELD_W*l +: MAP_FIELD_W]);
      end
      return int'(cfg_map_high[MAP_FIELD_W*(l - LOW_LAYERS) +: MAP_FIELD_W]);
   endfunction

   // Stores one accepted item; an item marked last produces the gated totals
   // of every reference layer and then empties the store.
   function automatic void absorb_score_item(score_item_type it);
      ref_total_type total;
      int sum;
      int hits;
      int p;
      int v;
      if (int'(it.layer) < NUM_LAYERS && int'(it.ref_layer) < NUM_REF_LAYERS) begin
         score_mem[it.layer][it.ref_layer] = it.score[SCORE_BITS-1:0];
         phi_mem[it.ref_layer] = it.ref_phi;
      end
      if (!it.last) begin
         return;
      end
      for (int r = 0; r < NUM_REF_LAYERS; r++) begin
         sum = 0;
         hits = 0;
         for (int l = 0; l < NUM_LAYERS; l++) begin
            p = partner_layer(l);
            v = 0;
            if (p < NUM_LAYERS && score_mem[p][r] != 0) begin
               v = int'(score_mem[l][r]);
            end
            sum += v;
            if (sum > 131071) begin
               sum = 131071;
            end
            if (v != 0 && !cfg_bending[l] && hits < 31) begin
               hits++;
            end
         end
         total.ref_layer   = r[REF_IN_W-1:0];
         total.score_sum   = sum[SUM_W-1:0];
         total.hit_count   = hits[HIT_W-1:0];
         total.ref_phi     = phi_mem[r];
         total.last_of_run = (r == NUM_REF_LAYERS - 1);
         expected_totals.push_back(total);
      end
      clear_event_store();
   endfunction

   function automatic void check_field(string name, logic signed [31:0] want_v,
                                       logic signed [31:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   // Monitor: tracks handshakes, keeps the shadow state and checks results.
   always @(posedge clock) begin
      score_item_type seen;
      ref_total_type  want;
      if (reset) begin
         item_accepted = 1'b0;
         csr_taken = 1'b0;
         cfg_bending  = BENDING_RESET;
         cfg_map_low  = MAP_LOW_RESET;
         cfg_map_high = MAP_HIGH_RESET;
         clear_event_store();
      end else begin
         item_accepted = start && !busy;
         csr_taken = csr_valid && csr_ready;
         if (csr_taken) begin
            case (csr_index)
               CSR_BENDING_MASK: cfg_bending  = csr_wdata[MASK_W-1:0];
               CSR_MAP_LOW:      cfg_map_low  = csr_wdata[MAP_LOW_W-1:0];
               CSR_MAP_HIGH:     cfg_map_high = csr_wdata[MAP_HIGH_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_totals.size() == 0) begin
               mismatch_count++;
               $display("%0t: result with no expected item, ref layer %0d sum %0d",
                        $time, rsp_out_ref_layer, rsp_score_sum);
            end else begin
               want = expected_totals.pop_front();
               check_field("out_ref_layer", want.ref_layer, rsp_out_ref_layer);
               check_field("score_sum", want.score_sum, rsp_score_sum);
               check_field("hit_count", want.hit_count, rsp_hit_count);
               check_field("out_ref_phi", want.ref_phi, rsp_out_ref_phi);
               check_field("last_of_run", want.last_of_run, rsp_last_of_run);
            end
         end
         if (item_accepted) begin
            items_taken++;
            seen.ref_layer = req_ref_layer;
            seen.layer     = req_layer;
            seen.score     = req_score;
            seen.ref_phi   = req_ref_phi;
            seen.last      = req_last;
            absorb_score_item(seen);
         end
      end
   end

   // Driver: presents queued items on the falling edge, with random idle bursts.
   always @(negedge clock) begin
      score_item_type next_item;
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else if (start && !item_accepted) begin
         // The block is busy; the item stays on the bus.
      end else if (gap_left > 0) begin
         start <= 1'b0;
         gap_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         start <= 1'b0;
         gap_left = $urandom_range(1, 15) - 1;
      end else if (pending_items.size() != 0) begin
         next_item = pending_items.pop_front();
         start         <= 1'b1;
         req_ref_layer <= next_item.ref_layer;
         req_layer     <= next_item.layer;
         req_score     <= next_item.score;
         req_ref_phi   <= next_item.ref_phi;
         req_last      <= next_item.last;
      end else begin
         start <= 1'b0;
      end
   end

   task automatic queue_item(int rl, int ly, int sc, int ph, bit last);
      score_item_type it;
      it.ref_layer = rl[REF_IN_W-1:0];
      it.layer     = ly[LAYER_IN_W-1:0];
      it.score     = sc[SCORE_IN_W-1:0];
      it.ref_phi   = ph[PHI_W-1:0];
      it.last      = last;
      pending_items.push_back(it);
      items_queued++;
   endtask

   // One event: mostly scores of one focus reference layer so that partner
   // gates open, some stray layers, and now and then an early end mark.
   task automatic queue_random_event();
      int n;
      int focus;
      int rl;
      int ly;
      int sc;
      n = $urandom_range(1, 24);
      focus = $urandom_range(0, NUM_REF_LAYERS - 1);
      for (int k = 0; k < n; k++) begin
         rl = ($urandom_range(0, 3) != 0) ? focus : $urandom_range(0, NUM_REF_LAYERS - 1);
         ly = ($urandom_range(0, 9) != 0) ? $urandom_range(0, NUM_LAYERS - 1)
                                          : $urandom_range(NUM_LAYERS, 31);
         case ($urandom_range(0, 9))
            0, 1: sc = 0;
            2: sc = 4095;
            default: sc = $urandom_range(1, 4095);
         endcase
         queue_item(rl, ly, sc, $urandom_range(0, 4095),
                    (k == n - 1) || ($urandom_range(0, 39) == 0));
      end
   endtask

   // Packed partner map: identity, random in range, or with out-of-range
   // partners mixed in. Bits above the fields are random.
   function automatic logic [CSR_DATA_W-1:0] build_map(int first_layer, int fields,
                                                       int mode);
      logic [CSR_DATA_W-1:0] v;
      int p;
      v = CSR_DATA_W'({$urandom, $urandom});
      for (int i = 0; i < fields; i++) begin
         case (mode)
            0: p = first_layer + i;
            1: p = $urandom_range(0, NUM_LAYERS - 1);
            default: p = ($urandom_range(0, 2) == 0) ? $urandom_range(NUM_LAYERS, 31)
                                                    : $urandom_range(0, NUM_LAYERS - 1);
         endcase
         v[MAP_FIELD_W*i +: MAP_FIELD_W] = p[MAP_FIELD_W-1:0];
      end
      return v;
   endfunction

   // Register write; called on a falling edge and returns on one.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (!csr_taken);
   endtask

   task automatic wait_for_results();
      while (items_taken != items_queued || expected_totals.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Sequence: reset, directed events on the reset settings, then random
   // events under several register settings.
   initial begin
      logic [CSR_DATA_W-1:0] mask_v;
      logic [CSR_DATA_W-1:0] low_v;
      logic [CSR_DATA_W-1:0] high_v;
      int phase_start;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // An event holding only an out-of-range item: all sums zero, phis at reset.
      queue_item(0, 31, 4095, -2048, 1'b1);
      // Extremes, a rewritten entry and a rewritten phi, a non-last item out of
      // range, and an event ended by an out-of-range last item.
      queue_item(7, 18, 123, 55, 1'b0);
      queue_item(0, 0, 4095, -2048, 1'b0);
      queue_item(0, 0, 1, 2047, 1'b0);
      queue_item(7, 17, 4095, 2047, 1'b0);
      queue_item(3, 5, 0, -1, 1'b0);
      queue_item(5, 9, 2048, 0, 1'b0);
      queue_item(6, 31, 0, 100, 1'b1);
      // Every layer of one reference layer at full score.
      for (int l = 0; l < NUM_LAYERS; l++) begin
         queue_item(2, l, 4095, 1365, l == NUM_LAYERS - 1);
      end
      wait_for_results();

      for (int phase = 0; phase < 6; phase++) begin
         repeat (SETTLE_CYCLES) @(negedge clock);
         case (phase)
            0: begin
               mask_v = CSR_DATA_W'({$urandom, $urandom});
               mask_v[MASK_W-1:0] = '1;
               low_v  = '0;
               high_v = CSR_DATA_W'({$urandom, 30'd0});
            end
            1: begin
               mask_v = '0;
               low_v  = '1;
               high_v = '1;
            end
            5: begin
               mask_v = CSR_DATA_W'(BENDING_RESET);
               low_v  = CSR_DATA_W'(MAP_LOW_RESET);
               high_v = CSR_DATA_W'(MAP_HIGH_RESET);
            end
            default: begin
               mask_v = CSR_DATA_W'({$urandom, $urandom});
               low_v  = build_map(0, LOW_LAYERS, phase - 2);
               high_v = build_map(LOW_LAYERS, MAPPED_LAYERS - LOW_LAYERS, phase - 2);
            end
         endcase
         write_csr(CSR_BENDING_MASK, mask_v);
         write_csr(CSR_MAP_LOW, low_v);
         write_csr(CSR_MAP_HIGH, high_v);
         csr_valid <= 1'b0;

         // The final phase runs without idle gaps.
         calm = (phase == 5);
         phase_start = items_queued;
         while (items_queued - phase_start < PHASE_ITEMS) begin
            queue_random_event();
         end
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && expected_totals.size() == 0) begin
         $display("** layer_score_gated_summer: PASSED **");
      end else begin
         $display("** layer_score_gated_summer: FAILED **");
      end
      $finish;
   end

endmodule
